>>> src/vmx_pkg.sv
`default_nettype none
package vmx_pkg;
	localparam int unsigned FuncW   = 2;
	localparam int unsigned IdW     = 32;
	localparam int unsigned TimeW   = 64;
	localparam int unsigned ReasonW = 10;
	localparam int unsigned CountW  = 32;
	localparam int unsigned CfgIdxW = 1;
	localparam int unsigned CfgW    = 32;

	typedef enum logic [FuncW-1:0] {
		FUNC_EXIT   = 2'd0,
		FUNC_ENTRY  = 2'd1,
		FUNC_SW_OUT = 2'd2,
		FUNC_SW_IN  = 2'd3
	} func_t;

	localparam logic [CfgIdxW-1:0] REG_TARGET_GROUP  = 1'b0;
	localparam logic [CfgIdxW-1:0] REG_TARGET_THREAD = 1'b1;

	typedef struct packed {
		logic [FuncW-1:0]   func;
		logic [IdW-1:0]     thread_id;
		logic [IdW-1:0]     group_id;
		logic [TimeW-1:0]   now_ns;
		logic [ReasonW-1:0] cause;
	} event_t;

	typedef struct packed {
		logic [ReasonW-1:0] reason;
		logic [TimeW-1:0]   total_time;
		logic [TimeW-1:0]   total_sched_time;
		logic [CountW-1:0]  exit_count;
	} result_t;
endpackage
`default_nettype wire

>>> src/vmx_if.sv
`default_nettype none
interface vmx_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> src/vm_exit_latency_accumulator.sv
// VM exit latency accumulator.
// Channel evt (sink) takes one event word: func, thread_id, group_id, now_ns,
// cause. Channel res (source) gives one word per vm entry that finds its
// thread with a reason below REASON_SLOTS: reason and the updated totals for it.
// Configuration: cfg_we, cfg_idx (0 target_group, 1 target_thread), cfg_data.
// After reset a clearing pass walks the reason counters, one entry per cycle,
// while evt.ready stays low.
// Each event that passes the target filter searches the thread table one slot
// per cycle: a scan of every slot, a check, a reread of the hit slot and an
// update; no new event is taken before this is through. An entry that hits
// then goes through the reason memory (read, then modify/write), and its
// result is registered in the output register at the modify/write step.
// evt.ready is low while an event is at work and while a result waits in the
// output register; a stalled receiver holds the result and no further event
// is taken. Reset clears the table's valid bits, the control and configuration
// registers and the output valid flag.
`default_nettype none
module vm_exit_latency_accumulator
	import vmx_pkg::*;
#(
	parameter int unsigned THREAD_SLOTS = 256,
	parameter int unsigned REASON_SLOTS = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	vmx_if.sink                     evt,
	vmx_if.source                   res,
	input  wire logic               cfg_we,
	input  wire logic [CfgIdxW-1:0] cfg_idx,
	input  wire logic [CfgW-1:0]    cfg_data
);
	localparam int unsigned SW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
	localparam int unsigned RW = $clog2(REASON_SLOTS);

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b00000001,
		ST_IDLE  = 8'b00000010,
		ST_SCAN  = 8'b00000100,
		ST_CHECK = 8'b00001000,
		ST_ACT   = 8'b00010000,
		ST_RRD   = 8'b00100000,
		ST_RWR   = 8'b01000000,
		ST_OUT   = 8'b10000000
	} state_t;

	state_t state_q;
	logic [IdW-1:0] tgt_group_q, tgt_thread_q;
	event_t ev_q;
	logic [SW:0] idx_q;          // scan address, holds the last slot at end
	logic        found_q, free_ok_q;
	logic [SW-1:0] hit_q, free_q;
	logic [RW:0] clr_q;
	result_t out_q;
	logic    out_vld_q;

	// thread table: valid bits in flops, fields in a memory
	logic [THREAD_SLOTS-1:0] valid_q;
	logic [IdW-1:0]     m_thr   [THREAD_SLOTS];
	logic [TimeW-1:0]   m_exit  [THREAD_SLOTS];
	logic [ReasonW-1:0] m_rsn   [THREAD_SLOTS];
	logic [TimeW-1:0]   m_sw    [THREAD_SLOTS];
	logic [TimeW-1:0]   m_sch   [THREAD_SLOTS];
	logic [IdW-1:0]     rd_thr_q;
	logic [TimeW-1:0]   rd_exit_q, rd_sw_q, rd_sch_q;
	logic [ReasonW-1:0] rd_rsn_q;
	logic [SW-1:0]      rd_addr_q;
	logic               rd_vld_q;

	logic [TimeW-1:0]  r_time  [REASON_SLOTS];
	logic [TimeW-1:0]  r_sched [REASON_SLOTS];
	logic [CountW-1:0] r_cnt   [REASON_SLOTS];
	logic [TimeW-1:0]  rr_time_q, rr_sched_q;
	logic [CountW-1:0] rr_cnt_q;

	logic accept, pass;
	logic [SW-1:0] rd_addr;
	logic [RW-1:0] rsn_idx;
	logic rsn_ok;

	assign accept = evt.valid && evt.ready;
	assign evt.ready = (state_q == ST_IDLE) && !out_vld_q;
	assign res.valid = out_vld_q;
	assign res.data  = out_q;
	assign pass = (tgt_group_q == '0 || tgt_group_q == evt.data.group_id) &&
		(tgt_thread_q == '0 || tgt_thread_q == evt.data.thread_id);
	assign rd_addr = (state_q == ST_SCAN) ? idx_q[SW-1:0] : hit_q;
	assign rsn_ok  = 32'(rd_rsn_q) < 32'(REASON_SLOTS);
	assign rsn_idx = RW'(rd_rsn_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_group_q  <= '0;
			tgt_thread_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_TARGET_GROUP:  tgt_group_q  <= cfg_data;
				REG_TARGET_THREAD: tgt_thread_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// slot memory read port, registered
	always_ff @(posedge clk) begin
		rd_thr_q  <= m_thr[rd_addr];
		rd_exit_q <= m_exit[rd_addr];
		rd_rsn_q  <= m_rsn[rd_addr];
		rd_sw_q   <= m_sw[rd_addr];
		rd_sch_q  <= m_sch[rd_addr];
		rd_addr_q <= rd_addr;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ACT) begin
			unique case (ev_q.func)
				FUNC_EXIT: begin
					if (found_q || free_ok_q) begin
						m_thr[found_q ? hit_q : free_q]  <= ev_q.thread_id;
						m_exit[found_q ? hit_q : free_q] <= ev_q.now_ns;
						m_rsn[found_q ? hit_q : free_q]  <= ev_q.cause;
						m_sw[found_q ? hit_q : free_q]   <= '0;
						m_sch[found_q ? hit_q : free_q]  <= '0;
					end
				end
				FUNC_SW_OUT: if (found_q) m_sw[hit_q] <= ev_q.now_ns;
				FUNC_SW_IN:
					if (found_q && rd_sw_q != '0)
						m_sch[hit_q] <= rd_sch_q + (ev_q.now_ns - rd_sw_q);
				default: ;
			endcase
		end
	end

	// reason counters: one read, one write per cycle
	always_ff @(posedge clk) begin
		rr_time_q  <= r_time[rsn_idx];
		rr_sched_q <= r_sched[rsn_idx];
		rr_cnt_q   <= r_cnt[rsn_idx];
		if (state_q == ST_CLEAR) begin
			r_time[clr_q[RW-1:0]]  <= '0;
			r_sched[clr_q[RW-1:0]] <= '0;
			r_cnt[clr_q[RW-1:0]]   <= '0;
		end else if (state_q == ST_RWR) begin
			r_time[rsn_idx]  <= rr_time_q + (ev_q.now_ns - rd_exit_q);
			r_sched[rsn_idx] <= rr_sched_q + rd_sch_q;
			r_cnt[rsn_idx]   <= rr_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) ev_q <= evt.data;
		if (state_q == ST_RWR) begin
			out_q.reason           <= rd_rsn_q;
			out_q.total_time       <= rr_time_q + (ev_q.now_ns - rd_exit_q);
			out_q.total_sched_time <= rr_sched_q + rd_sch_q;
			out_q.exit_count       <= rr_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			idx_q     <= '0;
			found_q   <= 1'b0;
			free_ok_q <= 1'b0;
			hit_q     <= '0;
			free_q    <= '0;
			rd_vld_q  <= 1'b0;
			valid_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (res.valid && res.ready) out_vld_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (RW+1)'(REASON_SLOTS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept && pass) begin
						idx_q     <= '0;
						found_q   <= 1'b0;
						free_ok_q <= 1'b0;
						rd_vld_q  <= 1'b0;
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// word read this cycle is compared next cycle
					rd_vld_q <= 1'b1;
					if (rd_vld_q && !found_q) begin
						if (valid_q[rd_addr_q] && rd_thr_q == ev_q.thread_id) begin
							found_q <= 1'b1;
							hit_q   <= rd_addr_q;
						end else if (!valid_q[rd_addr_q] && !free_ok_q) begin
							free_ok_q <= 1'b1;
							free_q    <= rd_addr_q;
						end
					end
					if (idx_q == (SW+1)'(THREAD_SLOTS - 1)) state_q <= ST_CHECK;
					else idx_q <= idx_q + 1'b1;
				end
				ST_CHECK: begin
					// last scanned word; then the hit slot is reread
					if (!found_q) begin
						if (valid_q[rd_addr_q] && rd_thr_q == ev_q.thread_id) begin
							found_q <= 1'b1;
							hit_q   <= rd_addr_q;
						end else if (!valid_q[rd_addr_q] && !free_ok_q) begin
							free_ok_q <= 1'b1;
							free_q    <= rd_addr_q;
						end
					end
					state_q <= ST_OUT;
				end
				ST_OUT: state_q <= ST_ACT; // hit slot read settles
				ST_ACT: begin
					if (ev_q.func == FUNC_EXIT && !found_q && free_ok_q)
						valid_q[free_q] <= 1'b1;
					if (ev_q.func == FUNC_ENTRY && found_q && rsn_ok) state_q <= ST_RRD;
					else state_q <= ST_IDLE;
				end
				ST_RRD: state_q <= ST_RWR;
				ST_RWR: begin
					out_vld_q <= 1'b1;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
